[rtl/tlc_pkg.sv]
package tlc_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned SensW  = 3;
  localparam int unsigned DwellW = 8;
  localparam int unsigned CarW   = 6;

  localparam logic [DwellW-1:0] DwellReset = 8'd15;

  // Light state codes.
  localparam logic [PhaseW-1:0] ST_GO_WEST    = 4'd0;
  localparam logic [PhaseW-1:0] ST_WAIT_WEST  = 4'd1;
  localparam logic [PhaseW-1:0] ST_GO_SOUTH   = 4'd2;
  localparam logic [PhaseW-1:0] ST_WAIT_SOUTH = 4'd3;
  localparam logic [PhaseW-1:0] ST_WALK       = 4'd4;
  localparam logic [PhaseW-1:0] ST_OFF_1      = 4'd5;
  localparam logic [PhaseW-1:0] ST_BLINK_1    = 4'd6;
  localparam logic [PhaseW-1:0] ST_OFF_2      = 4'd7;
  localparam logic [PhaseW-1:0] ST_BLINK_2    = 4'd8;
  localparam logic [PhaseW-1:0] ST_OFF_3      = 4'd9;
  localparam logic [PhaseW-1:0] ST_LAST_BLINK = 4'd10;

  // Sensor bit positions.
  localparam int unsigned SensPed = 2;
  localparam int unsigned SensNs  = 1;
  localparam int unsigned SensEw  = 0;

  // Car lamp patterns: east/west R,Y,G then north/south R,Y,G.
  localparam logic [CarW-1:0] CarGoWest    = 6'h0C;
  localparam logic [CarW-1:0] CarWaitWest  = 6'h14;
  localparam logic [CarW-1:0] CarGoSouth   = 6'h21;
  localparam logic [CarW-1:0] CarWaitSouth = 6'h22;
  localparam logic [CarW-1:0] CarAllRed    = 6'h24;

  typedef struct packed {
    logic [CarW-1:0]   car_lights;
    logic              walk_lamp;
    logic              dont_walk_lamp;
    logic [PhaseW-1:0] light_state;
  } tlc_lamps_t;

  // Lamps shown while a state is in force.
  function automatic tlc_lamps_t lamps_of(logic [PhaseW-1:0] s);
    tlc_lamps_t l;
    l.light_state    = s;
    l.walk_lamp      = 1'b0;
    l.dont_walk_lamp = 1'b1;
    unique case (s) inside
      ST_GO_WEST:    l.car_lights = CarGoWest;
      ST_WAIT_WEST:  l.car_lights = CarWaitWest;
      ST_GO_SOUTH:   l.car_lights = CarGoSouth;
      ST_WAIT_SOUTH: l.car_lights = CarWaitSouth;
      ST_WALK: begin
        l.car_lights     = CarAllRed;
        l.walk_lamp      = 1'b1;
        l.dont_walk_lamp = 1'b0;
      end
      ST_OFF_1, ST_OFF_2, ST_OFF_3: begin
        l.car_lights     = CarAllRed;
        l.dont_walk_lamp = 1'b0;
      end
      default: l.car_lights = CarAllRed;
    endcase
    return l;
  endfunction

  // Transition table, sampled on the last tick of a dwell.
  function automatic logic [PhaseW-1:0] next_phase(logic [PhaseW-1:0] s,
                                                   logic [SensW-1:0]  sens);
    logic [PhaseW-1:0] n;
    n = ST_GO_WEST;
    unique case (s)
      ST_GO_WEST:
        n = (sens[SensPed] | sens[SensNs]) ? ST_WAIT_WEST : ST_GO_WEST;
      ST_WAIT_WEST:
        n = sens[SensNs] ? ST_GO_SOUTH : (sens[SensPed] ? ST_WALK : ST_GO_WEST);
      ST_GO_SOUTH:
        n = (sens[SensPed] | sens[SensEw]) ? ST_WAIT_SOUTH : ST_GO_SOUTH;
      ST_WAIT_SOUTH:
        n = sens[SensPed] ? ST_WALK : (sens[SensEw] ? ST_GO_WEST : ST_GO_SOUTH);
      ST_WALK:
        n = (sens[SensNs] | sens[SensEw]) ? ST_OFF_1 : ST_WALK;
      ST_OFF_1:      n = ST_BLINK_1;
      ST_BLINK_1:    n = ST_OFF_2;
      ST_OFF_2:      n = ST_BLINK_2;
      ST_BLINK_2:    n = ST_OFF_3;
      ST_OFF_3:      n = ST_LAST_BLINK;
      ST_LAST_BLINK:
        n = sens[SensEw] ? ST_WAIT_WEST : (sens[SensNs] ? ST_WAIT_SOUTH : ST_WALK);
      default:       n = ST_GO_WEST;
    endcase
    return n;
  endfunction

endpackage

[rtl/tlc_fsm.sv]
module tlc_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [tlc_pkg::SensW-1:0]    sensors_i,
  input  logic [tlc_pkg::DwellW-1:0]   dwell_ticks_i,
  output tlc_pkg::tlc_lamps_t          lamps_o
);
  import tlc_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d, cur_phase;
  logic [DwellW-1:0] count_q, count_d;
  logic [DwellW:0]   count_inc;

  // Codes beyond the last state behave as go west.
  assign cur_phase = (phase_q > ST_LAST_BLINK) ? ST_GO_WEST : phase_q;
  assign count_inc = {1'b0, count_q} + {{DwellW{1'b0}}, 1'b1};
  assign lamps_o   = lamps_of(cur_phase);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (step_i) begin
      if (count_inc >= {1'b0, dwell_ticks_i}) begin
        phase_d = next_phase(cur_phase, sensors_i);
        count_d = '0;
      end else begin
        phase_d = cur_phase;
        count_d = count_inc[DwellW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_GO_WEST;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/traffic_light_moore_controller_top.sv]
// Moore traffic-light and pedestrian-crossing controller.
// Each input beat on the in channel is one 10 ms tick carrying the three
// sensor bits (pedestrian, north/south car, east/west car). Every tick yields
// exactly one output beat with the six car lamps, the walk and don't-walk
// lamps and the number of the state that was in force during that tick.
// The cfg channel writes the dwell length in ticks; it is always ready and
// should only be written while no tick is in flight.
// From input acceptance a tick passes through the input register, then the
// state step and lamp lookup land in the result register. Throughput is one
// tick per cycle while the receiver keeps out_ready_i high, set by the
// registered state and dwell-counter update.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more tick, after which in_ready_o drops until
// the result is taken.
// Reset puts the controller in the go west state with the dwell counter at
// zero and the dwell length at 15 ticks; both registers are empty.
module traffic_light_moore_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tlc_pkg::SensW-1:0]     sensors_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tlc_pkg::CarW-1:0]      car_lights_o,
  output logic                          walk_lamp_o,
  output logic                          dont_walk_lamp_o,
  output logic [tlc_pkg::PhaseW-1:0]    light_state_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tlc_pkg::DwellW-1:0]    dwell_ticks_i
);
  import tlc_pkg::*;

  logic              in_vld_q;
  logic [SensW-1:0]  sens_q;
  logic              out_vld_q;
  tlc_lamps_t        res_q;
  tlc_lamps_t        cur_lamps;
  logic [DwellW-1:0] dwell_q;
  logic              advance;

  // A held tick moves into the result register whenever that register is
  // empty or being drained in the same cycle.
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  tlc_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .sensors_i    (sens_q),
    .dwell_ticks_i(dwell_q),
    .lamps_o      (cur_lamps)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      dwell_q   <= DwellReset;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        dwell_q <= dwell_ticks_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sens_q <= sensors_i;
    end
    if (advance) begin
      res_q <= cur_lamps;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign car_lights_o     = res_q.car_lights;
  assign walk_lamp_o      = res_q.walk_lamp;
  assign dont_walk_lamp_o = res_q.dont_walk_lamp;
  assign light_state_o    = res_q.light_state;

endmodule

[rtl/tlc_checker.sv]
module tlc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tlc_pkg::CarW-1:0]      car_lights_o,
  input logic                          walk_lamp_o,
  input logic                          dont_walk_lamp_o,
  input logic [tlc_pkg::PhaseW-1:0]    light_state_o
);
  import tlc_pkg::*;

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> light_state_o <= ST_LAST_BLINK)
    else $error("light state out of range");

  a_walk_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && walk_lamp_o) |->
      (light_state_o == ST_WALK && !dont_walk_lamp_o && car_lights_o == CarAllRed))
    else $error("walk lamp outside the walk state");

  a_west_go_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && light_state_o == ST_GO_WEST) |->
      (car_lights_o == CarGoWest && dont_walk_lamp_o))
    else $error("wrong lamps in go west");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(light_state_o) && $stable(car_lights_o)))
    else $error("result changed while stalled");

endmodule

bind traffic_light_moore_controller_top tlc_checker u_tlc_checker (.*);

[dv/traffic_light_moore_controller_top_tb.sv]
`timescale 1ns / 100ps

// Testbench for the Moore traffic-light controller.
// Ticks go in on the in channel, each one a beat of three sensor bits. Every
// accepted tick is run through a cycle-free model of the controller, which
// pushes the lamp set it must produce. Each result beat is then checked
// against the oldest lamp set waiting.
// The dwell register is only written once the block has drained, so every
// expected beat is computed with the dwell value that the block will use.
module traffic_light_moore_controller_top_tb;
  import tlc_pkg::*;

  localparam int unsigned CycleLimit  = 100_000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReported = 10;

  // Sensor beats for the directed walk at a dwell of one tick. Starting in
  // wait west, this path visits every light state and reaches last blink.
  localparam logic [SensW-1:0] RouteSens[14] = '{
    3'd2, 3'd0, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4,
    3'd2, 3'd7, 3'd5, 3'd6, 3'd3, 3'd1, 3'd0
  };

  // Tracks the light state, the dwell counter and the dwell register, and
  // holds the lamp sets still owed by the block, oldest first.
  class tlc_lamp_tracker;
    logic [DwellW-1:0] dwell_ticks;
    logic [PhaseW-1:0] phase;
    logic [DwellW-1:0] dwell_count;
    tlc_lamps_t        expected_lamps[$];
    int unsigned       mismatches;

    function new();
      dwell_ticks = DwellReset;
      phase       = ST_GO_WEST;
      dwell_count = '0;
      mismatches  = 0;
    endfunction

    function void set_dwell(logic [DwellW-1:0] value);
      dwell_ticks = value;
    endfunction

    // One tick: record the lamps of the state in force now, then step.
    function void note_tick(logic [SensW-1:0] sens);
      logic [PhaseW-1:0] cur;
      logic [PhaseW-1:0] row[8];
      logic [DwellW:0]   count_next;
      tlc_lamps_t        lamps;
      // A state code past last blink is treated as go west.
      cur = (phase > ST_LAST_BLINK) ? ST_GO_WEST : phase;
      lamps.light_state    = cur;
      lamps.car_lights     = CarAllRed;
      lamps.walk_lamp      = 1'b0;
      lamps.dont_walk_lamp = 1'b1;
      case (cur)
        ST_WAIT_WEST: begin
          lamps.car_lights = CarWaitWest;
          row = '{ST_GO_WEST, ST_GO_WEST, ST_GO_SOUTH, ST_GO_SOUTH,
                  ST_WALK, ST_WALK, ST_GO_SOUTH, ST_GO_SOUTH};
        end
        ST_GO_SOUTH: begin
          lamps.car_lights = CarGoSouth;
          row = '{ST_GO_SOUTH, ST_WAIT_SOUTH, ST_GO_SOUTH, ST_WAIT_SOUTH,
                  ST_WAIT_SOUTH, ST_WAIT_SOUTH, ST_WAIT_SOUTH, ST_WAIT_SOUTH};
        end
        ST_WAIT_SOUTH: begin
          lamps.car_lights = CarWaitSouth;
          row = '{ST_GO_SOUTH, ST_GO_WEST, ST_GO_SOUTH, ST_GO_WEST,
                  ST_WALK, ST_WALK, ST_WALK, ST_WALK};
        end
        ST_WALK: begin
          lamps.walk_lamp      = 1'b1;
          lamps.dont_walk_lamp = 1'b0;
          row = '{ST_WALK, ST_OFF_1, ST_OFF_1, ST_OFF_1,
                  ST_WALK, ST_OFF_1, ST_OFF_1, ST_OFF_1};
        end
        ST_OFF_1: begin
          lamps.dont_walk_lamp = 1'b0;
          row = '{default: ST_BLINK_1};
        end
        ST_BLINK_1: row = '{default: ST_OFF_2};
        ST_OFF_2: begin
          lamps.dont_walk_lamp = 1'b0;
          row = '{default: ST_BLINK_2};
        end
        ST_BLINK_2: row = '{default: ST_OFF_3};
        ST_OFF_3: begin
          lamps.dont_walk_lamp = 1'b0;
          row = '{default: ST_LAST_BLINK};
        end
        ST_LAST_BLINK: begin
          row = '{ST_WALK, ST_WAIT_WEST, ST_WAIT_SOUTH, ST_WAIT_WEST,
                  ST_WALK, ST_WAIT_WEST, ST_WAIT_SOUTH, ST_WAIT_WEST};
        end
        default: begin
          lamps.car_lights = CarGoWest;
          row = '{ST_GO_WEST, ST_GO_WEST, ST_WAIT_WEST, ST_WAIT_WEST,
                  ST_WAIT_WEST, ST_WAIT_WEST, ST_WAIT_WEST, ST_WAIT_WEST};
        end
      endcase
      expected_lamps.push_back(lamps);

      // A dwell of zero behaves like one, and a dwell lowered below the
      // running count moves on at once; the compare covers both.
      count_next = {1'b0, dwell_count} + 1'b1;
      if (count_next >= {1'b0, dwell_ticks}) begin
        phase       = row[sens];
        dwell_count = '0;
      end else begin
        phase       = cur;
        dwell_count = count_next[DwellW-1:0];
      end
    endfunction

    function void check_lamps(tlc_lamps_t seen);
      tlc_lamps_t want;
      if (expected_lamps.size() == 0) begin
        if (mismatches < MaxReported) begin
          $display("%0t: result beat with none expected: car=%h walk=%b dont_walk=%b state=%0d",
                   $realtime, seen.car_lights, seen.walk_lamp, seen.dont_walk_lamp,
                   seen.light_state);
        end
        mismatches++;
        return;
      end
      want = expected_lamps.pop_front();
      if (seen.car_lights !== want.car_lights || seen.walk_lamp !== want.walk_lamp ||
          seen.dont_walk_lamp !== want.dont_walk_lamp ||
          seen.light_state !== want.light_state) begin
        if (mismatches < MaxReported) begin
          $display("%0t: lamp mismatch: expected car=%h walk=%b dont_walk=%b state=%0d",
                   $realtime, want.car_lights, want.walk_lamp, want.dont_walk_lamp,
                   want.light_state);
          $display("%0t:                   got car=%h walk=%b dont_walk=%b state=%0d",
                   $realtime, seen.car_lights, seen.walk_lamp, seen.dont_walk_lamp,
                   seen.light_state);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready_o;
  logic [SensW-1:0]  sensors;
  logic              out_valid_o;
  logic              out_ready;
  logic [CarW-1:0]   car_lights_o;
  logic              walk_lamp_o;
  logic              dont_walk_lamp_o;
  logic [PhaseW-1:0] light_state_o;
  logic              cfg_valid;
  logic              cfg_ready_o;
  logic [DwellW-1:0] cfg_dwell;

  // Idle bursts on the tick side and stalls on the result side; each phase
  // turns them on or off so that some stretches run at full rate.
  bit tick_gaps_on;
  bit ready_stalls_on;

  tlc_lamp_tracker tracker = new();

  traffic_light_moore_controller_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .sensors_i        (sensors),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .car_lights_o     (car_lights_o),
    .walk_lamp_o      (walk_lamp_o),
    .dont_walk_lamp_o (dont_walk_lamp_o),
    .light_state_o    (light_state_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .dwell_ticks_i    (cfg_dwell)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sends one tick beat, sometimes after an idle burst, and returns in the
  // time step of the edge that accepted it. Valid stays high into the next
  // beat unless that beat starts with a burst.
  task automatic send_tick(input logic [SensW-1:0] sens);
    if (tick_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sensors  <= sens;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_tick(sens);
  endtask

  // Lets every owed result beat come out, then keeps clocking so that any stray
  // beat still in the pipeline shows.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_lamps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_dwell(input logic [DwellW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_dwell <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_dwell(value);
    cfg_valid <= 1'b0;
  endtask

  // One setting of the dwell register followed by random sensor beats.
  task automatic run_phase(input logic [DwellW-1:0] dwell, input int unsigned n_ticks,
                           input bit quiet);
    drain();
    write_dwell(dwell);
    tick_gaps_on    = !quiet && $urandom_range(0, 3) != 0;
    ready_stalls_on = !quiet && $urandom_range(0, 3) != 0;
    repeat (n_ticks) send_tick(SensW'($urandom_range(0, 7)));
  endtask

  initial begin : stimulus
    logic [DwellW-1:0] dwell;
    tick_gaps_on    = 1'b1;
    ready_stalls_on = 1'b1;
    in_valid  <= 1'b0;
    sensors   <= '0;
    cfg_valid <= 1'b0;
    cfg_dwell <= '0;
    rst_ni    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // At the reset dwell of 15 ticks the controller sits in go west for 14
    // ticks whatever the sensors say, then samples on the 15th tick.
    for (int i = 0; i < 14; i++) send_tick(SensW'(i));
    send_tick(3'd3);

    // At a dwell of one tick, walk the whole cycle of light states.
    drain();
    write_dwell(8'd1);
    foreach (RouteSens[i]) send_tick(RouteSens[i]);

    // Dwell of zero, then the longest dwell, then a short one that lands
    // below the running count so the move happens on the next tick.
    run_phase(8'd0, 60, 1'b0);
    run_phase(8'd255, 200, 1'b0);
    run_phase(8'd3, 40, 1'b0);

    // Mostly short dwells so that sensor sampling happens often.
    for (int p = 0; p < 7; p++) begin
      case ($urandom_range(0, 5))
        0:       dwell = 8'd0;
        1:       dwell = 8'd1;
        2, 3:    dwell = DwellW'($urandom_range(2, 6));
        4:       dwell = DwellW'($urandom_range(7, 40));
        default: dwell = DwellW'($urandom_range(41, 255));
      endcase
      run_phase(dwell, 60, 1'b0);
    end

    // Final stretch at full rate on both sides.
    run_phase(DwellW'($urandom_range(1, 4)), 80, 1'b1);
    drain();

    if (tracker.mismatches == 0 && tracker.expected_lamps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: ready is high except for random stall bursts.
  initial begin : result_sink
    out_ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (ready_stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Values are read at the edge before the block's registers update, so an
  // accepted beat is the one both sides saw during the cycle before.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      tracker.check_lamps({car_lights_o, walk_lamp_o, dont_walk_lamp_o, light_state_o});
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
